/* design/hbu_pkg.sv */
// Shared types and constants for the horizontal blur 2x upscaler.
// Used by the front, the job queue and the back of the unit; no dependencies.
package hbu_pkg;

   localparam int PIX_W     = 32;
   localparam int CH_W      = 8;
   localparam int NUM_CH    = PIX_W / CH_W;
   localparam int ALPHA_W   = 9;
   localparam int COEF_W    = 7;
   localparam int WEIGHT_W  = 9;
   localparam int SUM_W     = 17;
   localparam int WEIGHT_ONE = 256;

   // Job queue between front and back.
   localparam int JOB_DEPTH = 4;
   localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
   localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

   // Result queue inside the back.
   localparam int RSP_DEPTH = 2;
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // One pending output pair: its pixel and both neighbors.
   typedef struct packed {
      logic [PIX_W-1:0] left;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] right;
      logic             last;
   } hbu_job_type;

   // Up to two jobs written by the front in one cycle.
   typedef struct packed {
      logic [1:0]  num;
      hbu_job_type job0;
      hbu_job_type job1;
   } hbu_push_type;

   // Head of the job queue as seen by the back.
   typedef struct packed {
      logic        valid;
      hbu_job_type job;
   } hbu_head_type;

   // One finished output pair.
   typedef struct packed {
      logic [PIX_W-1:0] even;
      logic [PIX_W-1:0] odd;
      logic             last;
   } hbu_rsp_type;

endpackage

/* design/horizontal_blur_upscale_2x_unit.sv */
// Horizontal 2x upscaler with blur: each 32-bit source pixel becomes one
// even/odd output pair, blended toward its left and right neighbors with a
// neighbor weight of csr_blur_alpha/4 out of 256. The unit takes one pixel
// per clock and delivers one pair per clock while neither side stalls; a
// pixel's pair leaves once its right neighbor has arrived, and the last
// pixel of a line releases two pairs, so a line of N pixels gives N pairs.
// With both queues empty, a pixel that releases a pair is written into the
// four-entry job queue, and the blend of the queue head is then registered
// into the two-entry result queue, which drives the rsp_ ports. The closing
// pair of a line is queued right behind the pair before it.
// req_full rises only when the output side stalls. Write csr_blur_alpha
// only while no pixels are in flight.
// Depends on hbu_pkg, hbu_front, hbu_job_queue and hbu_back.
module horizontal_blur_upscale_2x_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_pixel_in,
   input  logic        req_line_end,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_pixel_even,
   output logic [31:0] rsp_pixel_odd,
   output logic        rsp_last_of_line,
   input  logic        csr_write_en,
   input  logic [8:0]  csr_blur_alpha
);
   import hbu_pkg::*;

   hbu_push_type push;
   hbu_head_type head;
   hbu_rsp_type  rsp;
   logic         job_pop;
   logic         accept;

   assign accept = req_push && !req_full;

   // Front: neighbor tracking and job generation.
   hbu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .pixel_in (req_pixel_in),
      .line_end (req_line_end),
      .push     (push)
   );

   // Queue between front and back.
   hbu_job_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (job_pop),
      .head  (head),
      .full  (req_full)
   );

   // Back: blend and result queue.
   hbu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_blur_alpha),
      .head           (head),
      .job_pop        (job_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp            (rsp)
   );

   assign rsp_pixel_even   = rsp.even;
   assign rsp_pixel_odd    = rsp.odd;
   assign rsp_last_of_line = rsp.last;

endmodule

/* design/hbu_front.sv */
// Front of the upscaler: accepts source pixels, tracks the line neighbors
// and turns each pixel into zero, one or two blend jobs. Uses hbu_pkg.
module hbu_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [hbu_pkg::PIX_W-1:0] pixel_in,
   input  logic                     line_end,
   output hbu_pkg::hbu_push_type    push
);
   import hbu_pkg::*;

   logic             hold_ff, hold_in;
   logic [PIX_W-1:0] prev_ff, prev_in;
   logic [PIX_W-1:0] curr_ff, curr_in;
   hbu_job_type      mid_job;
   hbu_job_type      end_job;

   // Work out the jobs this pixel releases and the neighbors it leaves.
   always_comb begin
      hold_in = hold_ff;
      prev_in = prev_ff;
      curr_in = curr_ff;
      mid_job = '{left: prev_ff, mid: curr_ff, right: pixel_in, last: 1'b0};
      push    = '0;
      if (accept) begin
         if (hold_ff) begin
            prev_in  = curr_ff;
            curr_in  = pixel_in;
            push.num = 2'd1;
         end else begin
            prev_in  = pixel_in;
            curr_in  = pixel_in;
         end
         hold_in = !line_end;
      end
      end_job = '{left: prev_in, mid: curr_in, right: curr_in, last: 1'b1};
      // The held pair goes first; the closing pair follows it on a line end.
      push.job0 = hold_ff ? mid_job : end_job;
      push.job1 = end_job;
      if (accept && line_end) begin
         push.num = push.num + 2'd1;
      end
   end

   // Neighbor registers; only the hold flag needs reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
      end else begin
         hold_ff <= hold_in;
      end
      prev_ff <= prev_in;
      curr_ff <= curr_in;
   end

endmodule

/* design/hbu_job_queue.sv */
// Short queue of blend jobs between the front and the back. Takes up to two
// jobs a cycle and gives one when the back pops. Uses hbu_pkg.
module hbu_job_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  hbu_pkg::hbu_push_type push,
   input  logic                  pop,
   output hbu_pkg::hbu_head_type head,
   output logic                  full
);
   import hbu_pkg::*;

   hbu_job_type          slot_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [JOB_CNT_W-1:0] count_ff, count_in;
   logic [JOB_PTR_W-1:0] wr_next;
   logic                 do_pop;

   // Full means fewer than two free slots, so any accepted pixel fits.
   assign full       = count_ff > JOB_CNT_W'(JOB_DEPTH - 2);
   assign head.valid = count_ff != '0;
   assign head.job   = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;
   assign wr_next    = wr_ptr_ff + JOB_PTR_W'(1);

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + JOB_PTR_W'(push.num);
      rd_ptr_in = do_pop ? rd_ptr_ff + JOB_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + JOB_CNT_W'(push.num) - JOB_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage; the second job lands in the slot after the first.
   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push.job0;
      end
      if (push.num == 2'd2) begin
         slot_ff[wr_next] <= push.job1;
      end
   end

endmodule

/* design/hbu_back.sv */
// Back of the upscaler: holds the blur weight, blends one job a cycle into
// an output pair while the result queue has room or frees one, and keeps
// finished pairs in a two-entry result queue. Uses hbu_pkg.
module hbu_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [hbu_pkg::ALPHA_W-1:0] csr_write_data,
   input  hbu_pkg::hbu_head_type      head,
   output logic                       job_pop,
   input  logic                       rsp_pop,
   output logic                       rsp_empty,
   output hbu_pkg::hbu_rsp_type       rsp
);
   import hbu_pkg::*;

   logic [ALPHA_W-1:0]   alpha_ff;
   hbu_rsp_type          entry_ff [RSP_DEPTH];
   hbu_rsp_type          result;
   logic                 wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic [COEF_W-1:0]    c1;
   logic                 do_pop;

   // Per-channel (c1*side + (256-c1)*mid) >> 8.
   function automatic logic [PIX_W-1:0] blend(input logic [PIX_W-1:0] side,
                                              input logic [PIX_W-1:0] mid,
                                              input logic [COEF_W-1:0] coef);
      logic [WEIGHT_W-1:0] c2;
      logic [SUM_W-1:0]    sum;
      logic [PIX_W-1:0]    res;
      c2  = WEIGHT_W'(WEIGHT_ONE) - WEIGHT_W'(coef);
      res = '0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         sum = SUM_W'(coef) * SUM_W'(side[ch*CH_W +: CH_W])
             + SUM_W'(c2) * SUM_W'(mid[ch*CH_W +: CH_W]);
         res[ch*CH_W +: CH_W] = sum[2*CH_W-1:CH_W];
      end
      return res;
   endfunction

   // Blur weight register.
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= '0;
      end else if (csr_write_en) begin
         alpha_ff <= csr_write_data;
      end
   end

   assign c1 = alpha_ff[ALPHA_W-1:2];

   // Blend the queue head.
   always_comb begin
      result.even = blend(head.job.left, head.job.mid, c1);
      result.odd  = blend(head.job.right, head.job.mid, c1);
      result.last = head.job.last;
   end

   // A job moves on when the result queue has room or frees one now.
   assign rsp_empty = count_ff == '0;
   assign do_pop    = rsp_pop && !rsp_empty;
   assign job_pop   = head.valid && (count_ff != RSP_CNT_W'(RSP_DEPTH) || do_pop);
   assign rsp       = entry_ff[rd_ptr_ff];
   assign count_in  = count_ff + RSP_CNT_W'(job_pop) - RSP_CNT_W'(do_pop);

   // Result queue control.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff ^ job_pop;
         rd_ptr_ff <= rd_ptr_ff ^ do_pop;
         count_ff  <= count_in;
      end
   end

   // Result storage.
   always_ff @(posedge clock) begin
      if (job_pop) begin
         entry_ff[wr_ptr_ff] <= result;
      end
   end

endmodule

/* design/hbu_checker.sv */
// Port-level checks for the horizontal blur 2x upscaler, bound to its top
// level. Depends only on the top level's ports.
module hbu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [31:0] rsp_pixel_even,
   input logic [31:0] rsp_pixel_odd,
   input logic        rsp_last_of_line
);

   // Reset leaves no result waiting.
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // Reset leaves room for input.
   a_room_after_reset: assert property (@(posedge clock)
      reset |=> !req_full)
      else $error("input side full after reset");

   // The input side only backs up while a result is waiting.
   a_full_needs_backlog: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !rsp_empty)
      else $error("input stalled with no result waiting");

   // A waiting result that is not taken stays, unchanged.
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_pixel_even) && $stable(rsp_pixel_odd)
          && $stable(rsp_last_of_line)))
      else $error("waiting result changed or vanished");

endmodule

bind horizontal_blur_upscale_2x_unit hbu_checker u_hbu_checker (
   .clock            (clock),
   .reset            (reset),
   .req_full         (req_full),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_pixel_even   (rsp_pixel_even),
   .rsp_pixel_odd    (rsp_pixel_odd),
   .rsp_last_of_line (rsp_last_of_line)
);

/* verif/upscale_pair_checker.sv */
// Checker for the horizontal blur 2x upscaler: predicts each output pair
// from the accepted pixel beats and compares it with the beats leaving the unit.
// Depends only on the port list of horizontal_blur_upscale_2x_unit.
module upscale_pair_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [31:0] req_pixel_in,
   input  logic        req_line_end,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [31:0] rsp_pixel_even,
   input  logic [31:0] rsp_pixel_odd,
   input  logic        rsp_last_of_line,
   input  logic        csr_write_en,
   input  logic [8:0]  csr_blur_alpha,
   output int          mismatch_count,
   output int          pending_pairs
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] even;
      logic [31:0] odd;
      logic        last;
   } upscaled_pair_type;

   upscaled_pair_type awaited_pairs[$];

   // Shadow of the unit's configuration and line state.
   logic [8:0]  blur_weight;
   logic [31:0] left_pixel;
   logic [31:0] held_pixel;
   logic        pixel_held;

   initial begin
      mismatch_count = 0;
      pending_pairs  = 0;
   end

   // Per channel (c1*side + c2*mid) >> 8 with c1 = alpha/4 and c2 = 256 - c1.
   function automatic logic [31:0] blend_toward(input logic [8:0] alpha,
                                                input logic [31:0] side,
                                                input logic [31:0] mid);
      logic [16:0] c1;
      logic [16:0] c2;
      logic [16:0] acc;
      logic [31:0] blended;
      c1 = {10'd0, alpha[8:2]};
      c2 = 17'd256 - c1;
      blended = '0;
      for (int ch = 0; ch < 4; ch++) begin
         acc = c1 * {9'd0, side[ch*8 +: 8]} + c2 * {9'd0, mid[ch*8 +: 8]};
         blended[ch*8 +: 8] = acc[15:8];
      end
      return blended;
   endfunction

   function automatic upscaled_pair_type make_pair(input logic [31:0] left,
                                                   input logic [31:0] mid,
                                                   input logic [31:0] right,
                                                   input logic last);
      upscaled_pair_type pair;
      pair.even = blend_toward(blur_weight, left, mid);
      pair.odd  = blend_toward(blur_weight, right, mid);
      pair.last = last;
      return pair;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns checker: %s", $time, what);
      mismatch_count++;
   endtask

   // Works out the pairs that one accepted pixel beat releases.
   task automatic predict_pairs(input logic [31:0] pix, input logic line_end);
      if (!pixel_held) begin
         // A new line: the pixel is its own left neighbor.
         left_pixel = pix;
         held_pixel = pix;
      end else begin
         awaited_pairs.push_back(make_pair(left_pixel, held_pixel, pix, 1'b0));
         left_pixel = held_pixel;
         held_pixel = pix;
      end
      if (line_end) begin
         // The last pixel of a line is its own right neighbor.
         awaited_pairs.push_back(make_pair(left_pixel, held_pixel, held_pixel, 1'b1));
         pixel_held = 1'b0;
      end else begin
         pixel_held = 1'b1;
      end
   endtask

   // Watch both channels and the register port at every edge.
   always @(posedge clock) begin
      upscaled_pair_type want;
      if (reset) begin
         blur_weight = '0;
         left_pixel  = '0;
         held_pixel  = '0;
         pixel_held  = 1'b0;
         awaited_pairs.delete();
      end else begin
         if (csr_write_en) begin
            blur_weight = csr_blur_alpha;
         end
         if (req_push && !req_full) begin
            predict_pairs(req_pixel_in, req_line_end);
         end
         if (rsp_pop && !rsp_empty) begin
            if (awaited_pairs.size() == 0) begin
               report_mismatch($sformatf("unexpected pair even=%h odd=%h last=%b",
                                         rsp_pixel_even, rsp_pixel_odd, rsp_last_of_line));
            end else begin
               want = awaited_pairs.pop_front();
               if (rsp_pixel_even !== want.even)
                  report_mismatch($sformatf("pixel_even %h, expected %h",
                                            rsp_pixel_even, want.even));
               if (rsp_pixel_odd !== want.odd)
                  report_mismatch($sformatf("pixel_odd %h, expected %h",
                                            rsp_pixel_odd, want.odd));
               if (rsp_last_of_line !== want.last)
                  report_mismatch($sformatf("last_of_line %b, expected %b",
                                            rsp_last_of_line, want.last));
            end
         end
      end
      pending_pairs <= awaited_pairs.size();
   end

endmodule

/* verif/horizontal_blur_upscale_2x_unit_tb.sv */
// Testbench top for horizontal_blur_upscale_2x_unit: drives pixel lines and
// register writes under several idle and stall mixes and gives the verdict.
// Depends on the unit and on upscale_pair_checker.
module horizontal_blur_upscale_2x_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int ITEMS_PER_PASS = 250;
   localparam int SETTLE_CYCLES  = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [31:0] req_pixel_in = '0;
   logic        req_line_end = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [31:0] rsp_pixel_even;
   logic [31:0] rsp_pixel_odd;
   logic        rsp_last_of_line;
   logic        csr_write_en = 1'b0;
   logic [8:0]  csr_blur_alpha = '0;

   int mismatch_count;
   int pending_pairs;
   int cycle_count = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   horizontal_blur_upscale_2x_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_pixel_in     (req_pixel_in),
      .req_line_end     (req_line_end),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_pixel_even   (rsp_pixel_even),
      .rsp_pixel_odd    (rsp_pixel_odd),
      .rsp_last_of_line (rsp_last_of_line),
      .csr_write_en     (csr_write_en),
      .csr_blur_alpha   (csr_blur_alpha)
   );

   upscale_pair_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_pixel_in     (req_pixel_in),
      .req_line_end     (req_line_end),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_pixel_even   (rsp_pixel_even),
      .rsp_pixel_odd    (rsp_pixel_odd),
      .rsp_last_of_line (rsp_last_of_line),
      .csr_write_en     (csr_write_en),
      .csr_blur_alpha   (csr_blur_alpha),
      .mismatch_count   (mismatch_count),
      .pending_pairs    (pending_pairs)
   );

   // Result side: pop is redrawn every cycle against the current stall rate.
   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= stall_pct);
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Sends one pixel beat; push stays high on return so back-to-back beats
   // never lower and raise it within one edge.
   task automatic push_pixel(input logic [31:0] pix, input logic line_end);
      while ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push     <= 1'b1;
      req_pixel_in <= pix;
      req_line_end <= line_end;
      do @(posedge clock); while (req_full);
   endtask

   // Lets every pair drain, then lets anything still in flight settle.
   task automatic drain_unit();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_pairs != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_alpha(input logic [8:0] alpha);
      csr_write_en   <= 1'b1;
      csr_blur_alpha <= alpha;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // Mix of uniform pixels, saturated channels and fully random pixels.
   function automatic logic [31:0] draw_pixel();
      logic [31:0] pix;
      pix = $urandom();
      case ($urandom_range(3))
         0: begin
            // Each channel takes its own bit from the top channel.
            for (int ch = 0; ch < 4; ch++)
               pix[ch*8 +: 8] = pix[31-ch] ? 8'hff : 8'h00;
         end
         1: begin
            pix = {4{pix[7:0]}} ^ {4{6'd0, pix[9:8]}};
         end
         default: begin
         end
      endcase
      return pix;
   endfunction

   // One random line: mostly short, some single pixel, a few long.
   task automatic send_line(output int length);
      int pick;
      pick = $urandom_range(99);
      if (pick < 10)
         length = 1;
      else if (pick < 85)
         length = $urandom_range(2, 8);
      else
         length = $urandom_range(9, 48);
      for (int i = 0; i < length; i++)
         push_pixel(draw_pixel(), i == length - 1);
   endtask

   initial begin
      int idle_mix[4];
      int stall_mix[4];
      int sent;
      int length;
      logic [8:0] alpha;

      idle_mix  = '{0, 48, 0, 10};
      stall_mix = '{0, 0, 48, 10};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed lines. Reset weight first: plain duplication.
      push_pixel(32'h0000_0000, 1'b0);
      push_pixel(32'hffff_ffff, 1'b0);
      push_pixel(32'h1234_5678, 1'b1);
      drain_unit();

      // Full blend weight: single-pixel line and sharp edges.
      write_alpha(9'd256);
      push_pixel(32'hffff_ffff, 1'b1);
      push_pixel(32'h0000_0000, 1'b0);
      push_pixel(32'hffff_ffff, 1'b1);
      push_pixel(32'hff00_ff00, 1'b0);
      push_pixel(32'h00ff_00ff, 1'b0);
      push_pixel(32'hd8ee_4400, 1'b0);
      push_pixel(32'h0000_0000, 1'b1);
      drain_unit();

      // Weight above range: alternating black and white.
      write_alpha(9'd511);
      push_pixel(32'hffff_ffff, 1'b0);
      push_pixel(32'h0000_0000, 1'b0);
      push_pixel(32'hffff_ffff, 1'b0);
      push_pixel(32'h0000_0000, 1'b1);
      push_pixel(32'h0000_0000, 1'b1);
      drain_unit();

      // Weight below four still duplicates.
      write_alpha(9'd3);
      push_pixel(32'hdead_beef, 1'b0);
      push_pixel(32'h0123_4567, 1'b1);
      drain_unit();

      // Random passes, two per idle and stall mix, each with its own weight.
      for (int pass = 0; pass < 8; pass++) begin
         case (pass)
            0: alpha = 9'd256;
            2: alpha = 9'd0;
            3: alpha = 9'd511;
            5: alpha = 9'd4;
            6: alpha = 9'd255;
            default: alpha = 9'($urandom_range(511));
         endcase
         write_alpha(alpha);
         idle_pct  = idle_mix[pass % 4];
         stall_pct = stall_mix[pass % 4];
         sent = 0;
         while (sent < ITEMS_PER_PASS) begin
            send_line(length);
            sent += length;
         end
         drain_unit();
      end

      if (mismatch_count == 0 && pending_pairs == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

/* sim.f */
design/hbu_pkg.sv
design/hbu_front.sv
design/hbu_job_queue.sv
design/hbu_back.sv
design/horizontal_blur_upscale_2x_unit.sv
design/hbu_checker.sv
verif/upscale_pair_checker.sv
verif/horizontal_blur_upscale_2x_unit_tb.sv
